[design/rwcp_pkg.sv]
// Shared constants, types and the divider step for the wall column projection block.
// No dependencies; imported by rwcp_frontend, ray_wall_column_projection and the testbench.
`default_nettype none
package rwcp_pkg;

	localparam int SCREEN_ROWS    = 480;
	localparam int TEXTURE_WIDTH  = 64;
	localparam int TEXTURE_HEIGHT = 64;
	localparam int FRAC           = 16;

	localparam int POS_W   = 22;
	localparam int DIR_W   = 24;
	localparam int CELL_W  = 6;
	localparam int NUM_W   = POS_W + 1;            // |num| reaches 2^22
	localparam int PERP_W  = 32;
	localparam int LH_W    = 16;
	localparam int ROW_W   = 9;
	localparam int COL_W   = 6;
	localparam int STEP_W  = 24;
	localparam int START_W = 23;
	localparam int REM_W   = PERP_W;               // widest divisor

	// quotient bits of each divider
	localparam int D1_STEPS = NUM_W + FRAC;
	localparam int D2_STEPS = $clog2(SCREEN_ROWS * (2 ** FRAC) + 1);
	localparam int D3_STEPS = $clog2(TEXTURE_HEIGHT * (2 ** FRAC) + 1);

	localparam logic [D2_STEPS-1:0] LH_NUM   = D2_STEPS'(SCREEN_ROWS * (2 ** FRAC));
	localparam logic [D3_STEPS-1:0] STEP_NUM = D3_STEPS'(TEXTURE_HEIGHT * (2 ** FRAC));

	localparam int HALF_ROWS = SCREEN_ROWS / 2;
	localparam logic [LH_W-1:0]    LH_MAX    = '1;
	localparam logic [PERP_W-1:0]  PERP_MAX  = '1;
	localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
	localparam logic [START_W-1:0] START_MAX = START_W'((2 ** (START_W - 1)) - 1);

	typedef struct packed {
		logic [NUM_W-1:0]        abs_num;
		logic [DIR_W-1:0]        abs_dir;
		logic                    q_pos;      // quotient sign positive and num nonzero
		logic                    dir_zero;
		logic [POS_W-1:0]        wall_pos;
		logic signed [DIR_W-1:0] wall_dir;
		logic                    mirror;
	} front_t;

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
			input logic nbit, input logic [REM_W-1:0] dv);
		logic [REM_W:0] t;
		logic [REM_W:0] d;
		t = {rem, nbit};
		d = {1'b0, dv};
		if (t >= d) begin
			div_step = {1'b1, REM_W'(t - d)};
		end else begin
			div_step = {1'b0, t[REM_W-1:0]};
		end
	endfunction

endpackage
`default_nettype wire

[design/ray_wall_column_projection.sv]
// Top level of the wall column projection: pipelined dividers, texture mapping, output register.
// Depends on rwcp_pkg and rwcp_frontend.
//
//  channel | dir | handshake         | word contents (lowest bit up)
//  s_*     | in  | s_tvalid/s_tready | tdata: viewer_x, viewer_y, dir_x, dir_y, hit_cell_x,
//          |     |                   |        hit_cell_y; tuser: hit_face
//  m_*     | out | m_tvalid/m_tready | tdata: wall_rows, top_row, bottom_row, tex_column,
//          |     |                   |        tex_step, tex_start, one pad bit
//
// One ray word per cycle while the output register is empty or being taken.
// The three bit-per-stage restoring dividers have 39, 25 and 23 step stages, each behind its own
// input register, plus clamp, multiply, column, saturate, row, product and output stages.
// arst_n clears the valid bits only; data registers are not reset.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stall freezes every stage and no word is lost or repeated.
`default_nettype none
module ray_wall_column_projection import rwcp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,   // viewer_x, viewer_y, dir_x, dir_y, hit_cell_x, hit_cell_y
	input  wire logic [0:0]   s_tuser,   // hit_face
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [87:0]       m_tdata    // wall_rows, top_row, bottom_row, tex_column,
	                                     // tex_step, tex_start, pad
);

	logic   adv;
	front_t front;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	rwcp_frontend u_frontend (
		.viewer_x   (s_tdata[21:0]),
		.viewer_y   (s_tdata[43:22]),
		.dir_x      (s_tdata[67:44]),
		.dir_y      (s_tdata[91:68]),
		.hit_cell_x (s_tdata[97:92]),
		.hit_cell_y (s_tdata[103:98]),
		.hit_face   (s_tuser[0]),
		.front      (front)
	);

	// ---------------- distance divide: |num|*2^16 / |dir| ----------------
	// element 0 is the input register (s1)
	front_t              d1_f_s   [0:D1_STEPS];
	logic [REM_W-1:0]    d1_rem_s [0:D1_STEPS];
	logic [D1_STEPS-1:0] d1_quo_s [0:D1_STEPS];
	logic [D1_STEPS:0]   d1_v_s;
	logic [REM_W:0]      d1_res   [1:D1_STEPS];
	logic [D1_STEPS-1:0] d1_dvd   [0:D1_STEPS-1];

	always_comb begin
		for (int k = 1; k <= D1_STEPS; k++) begin
			d1_dvd[k-1] = {d1_f_s[k-1].abs_num, {FRAC{1'b0}}};
			d1_res[k] = div_step(d1_rem_s[k-1], d1_dvd[k-1][D1_STEPS-k],
				REM_W'(d1_f_s[k-1].abs_dir));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_f_s[0]   <= front;
			d1_rem_s[0] <= '0;
			d1_quo_s[0] <= '0;
			for (int k = 1; k <= D1_STEPS; k++) begin
				d1_f_s[k]   <= d1_f_s[k-1];
				d1_rem_s[k] <= d1_res[k][REM_W-1:0];
				d1_quo_s[k] <= {d1_quo_s[k-1][D1_STEPS-2:0], d1_res[k][REM_W]};
			end
		end
	end

	// ---------------- s2: clamp the distance ----------------
	logic [PERP_W-1:0]       perp_s2;
	logic [POS_W-1:0]        wpos_s2;
	logic signed [DIR_W-1:0] wdir_s2;
	logic                    mir_s2;
	logic [PERP_W-1:0]       perp_c;
	front_t                  f_last;
	logic [D1_STEPS-1:0]     q_last;

	always_comb begin
		f_last = d1_f_s[D1_STEPS];
		q_last = d1_quo_s[D1_STEPS];
		if (f_last.dir_zero) begin
			perp_c = PERP_MAX;
		end else if (!f_last.q_pos) begin
			perp_c = '0;   // wall behind the viewer or on it
		end else if (|q_last[D1_STEPS-1:PERP_W]) begin
			perp_c = PERP_MAX;
		end else begin
			perp_c = q_last[PERP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			perp_s2 <= perp_c;
			wpos_s2 <= f_last.wall_pos;
			wdir_s2 <= f_last.wall_dir;
			mir_s2  <= f_last.mirror;
		end
	end

	// ---------------- s3: perp * dir, low 32 bits ----------------
	logic [PERP_W-1:0] prod_s3;
	logic [PERP_W-1:0] perp_s3;
	logic [POS_W-1:0]  wpos_s3;
	logic              mir_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= perp_s2 * PERP_W'(wdir_s2);
			perp_s3 <= perp_s2;
			wpos_s3 <= wpos_s2;
			mir_s3  <= mir_s2;
		end
	end

	// ---------------- s4: wall fraction to texture column ----------------
	logic [PERP_W-1:0] wall_c;
	logic [31:0]       colw_c;
	logic [COL_W-1:0]  col_c;
	logic [COL_W-1:0]  col_s4;
	logic [PERP_W-1:0] perp_s4;

	always_comb begin
		wall_c = PERP_W'({wpos_s3, {FRAC{1'b0}}}) + prod_s3;
		colw_c = (32'(wall_c[PERP_W-1:FRAC]) * 32'(TEXTURE_WIDTH)) >> FRAC;
		col_c  = mir_s3 ? COL_W'(32'(TEXTURE_WIDTH - 1) - colw_c) : COL_W'(colw_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s4  <= col_c;
			perp_s4 <= perp_s3;
		end
	end

	// ---------------- line height divide: rows*2^16 / perp ----------------
	logic [PERP_W-1:0]   d2_dv_s  [0:D2_STEPS];
	logic [COL_W-1:0]    d2_col_s [0:D2_STEPS];
	logic [REM_W-1:0]    d2_rem_s [0:D2_STEPS];
	logic [D2_STEPS-1:0] d2_quo_s [0:D2_STEPS];
	logic [D2_STEPS:0]   d2_v_s;
	logic [REM_W:0]      d2_res   [1:D2_STEPS];

	always_comb begin
		for (int k = 1; k <= D2_STEPS; k++) begin
			d2_res[k] = div_step(d2_rem_s[k-1], LH_NUM[D2_STEPS-k], d2_dv_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_dv_s[0]  <= perp_s4;
			d2_col_s[0] <= col_s4;
			d2_rem_s[0] <= '0;
			d2_quo_s[0] <= '0;
			for (int k = 1; k <= D2_STEPS; k++) begin
				d2_dv_s[k]  <= d2_dv_s[k-1];
				d2_col_s[k] <= d2_col_s[k-1];
				d2_rem_s[k] <= d2_res[k][REM_W-1:0];
				d2_quo_s[k] <= {d2_quo_s[k-1][D2_STEPS-2:0], d2_res[k][REM_W]};
			end
		end
	end

	// ---------------- s5: saturate line height ----------------
	logic [LH_W-1:0]     lh_c;
	logic [LH_W-1:0]     lh_s5;
	logic [COL_W-1:0]    col_s5;
	logic [D2_STEPS-1:0] q2_last;

	always_comb begin
		q2_last = d2_quo_s[D2_STEPS];
		if (d2_dv_s[D2_STEPS] == '0 || |q2_last[D2_STEPS-1:LH_W]) begin
			lh_c = LH_MAX;
		end else begin
			lh_c = q2_last[LH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lh_s5  <= lh_c;
			col_s5 <= d2_col_s[D2_STEPS];
		end
	end

	// ---------------- texture step divide: height*2^16 / line height ----------------
	logic [LH_W-1:0]     d3_lh_s  [0:D3_STEPS];
	logic [COL_W-1:0]    d3_col_s [0:D3_STEPS];
	logic [REM_W-1:0]    d3_rem_s [0:D3_STEPS];
	logic [D3_STEPS-1:0] d3_quo_s [0:D3_STEPS];
	logic [D3_STEPS:0]   d3_v_s;
	logic [REM_W:0]      d3_res   [1:D3_STEPS];

	always_comb begin
		for (int k = 1; k <= D3_STEPS; k++) begin
			d3_res[k] = div_step(d3_rem_s[k-1], STEP_NUM[D3_STEPS-k],
				REM_W'(d3_lh_s[k-1]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d3_lh_s[0]  <= lh_s5;
			d3_col_s[0] <= col_s5;
			d3_rem_s[0] <= '0;
			d3_quo_s[0] <= '0;
			for (int k = 1; k <= D3_STEPS; k++) begin
				d3_lh_s[k]  <= d3_lh_s[k-1];
				d3_col_s[k] <= d3_col_s[k-1];
				d3_rem_s[k] <= d3_res[k][REM_W-1:0];
				d3_quo_s[k] <= {d3_quo_s[k-1][D3_STEPS-2:0], d3_res[k][REM_W]};
			end
		end
	end

	// ---------------- s6: step, draw rows, rows hidden above the screen ----------------
	logic [LH_W-1:0]   lh_l;
	logic [LH_W-1:0]   h2_c;
	logic [LH_W:0]     de_sum;
	logic [STEP_W-1:0] step_c;
	logic [ROW_W-1:0]  ds_c;
	logic [ROW_W-1:0]  de_c;
	logic [LH_W-1:0]   hit_c;

	logic [LH_W-1:0]   lh_s6;
	logic [ROW_W-1:0]  ds_s6;
	logic [ROW_W-1:0]  de_s6;
	logic [COL_W-1:0]  col_s6;
	logic [STEP_W-1:0] step_s6;
	logic [LH_W-1:0]   hit_s6;

	always_comb begin
		lh_l   = d3_lh_s[D3_STEPS];
		h2_c   = lh_l >> 1;
		step_c = (lh_l == '0) ? STEP_MAX : STEP_W'(d3_quo_s[D3_STEPS]);
		if (h2_c >= LH_W'(HALF_ROWS)) begin
			ds_c  = '0;
			hit_c = h2_c - LH_W'(HALF_ROWS);
		end else begin
			ds_c  = ROW_W'(LH_W'(HALF_ROWS) - h2_c);
			hit_c = '0;
		end
		de_sum = (LH_W+1)'(HALF_ROWS) + {1'b0, h2_c};
		de_c   = (de_sum > (LH_W+1)'(SCREEN_ROWS - 1)) ? ROW_W'(SCREEN_ROWS - 1)
		                                               : ROW_W'(de_sum);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lh_s6   <= lh_l;
			ds_s6   <= ds_c;
			de_s6   <= de_c;
			col_s6  <= d3_col_s[D3_STEPS];
			step_s6 <= step_c;
			hit_s6  <= hit_c;
		end
	end

	// ---------------- s7: texture start product ----------------
	logic [LH_W+STEP_W-1:0] start_s7;
	logic [LH_W-1:0]        lh_s7;
	logic [ROW_W-1:0]       ds_s7;
	logic [ROW_W-1:0]       de_s7;
	logic [COL_W-1:0]       col_s7;
	logic [STEP_W-1:0]      step_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s7 <= hit_s6 * step_s6;
			lh_s7    <= lh_s6;
			ds_s7    <= ds_s6;
			de_s7    <= de_s6;
			col_s7   <= col_s6;
			step_s7  <= step_s6;
		end
	end

	// ---------------- output register ----------------
	logic [START_W-1:0] start_c;

	always_comb begin
		if (start_s7 > (LH_W+STEP_W)'(START_MAX)) begin
			start_c = START_MAX;
		end else begin
			start_c = START_W'(start_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {1'b0, start_c, step_s7, col_s7, de_s7, ds_s7, lh_s7};
		end
	end

	// ---------------- valid bits ----------------
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_v_s   <= '0;
			d2_v_s   <= '0;
			d3_v_s   <= '0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			d1_v_s   <= {d1_v_s[D1_STEPS-1:0], s_tvalid};
			v_s2     <= d1_v_s[D1_STEPS];
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			d2_v_s   <= {d2_v_s[D2_STEPS-1:0], v_s4};
			v_s5     <= d2_v_s[D2_STEPS];
			d3_v_s   <= {d3_v_s[D3_STEPS-1:0], v_s5};
			v_s6     <= d3_v_s[D3_STEPS];
			v_s7     <= v_s6;
			m_tvalid <= v_s7;
		end
	end

endmodule
`default_nettype wire

[design/rwcp_frontend.sv]
// Axis selection and numerator set-up for the perpendicular distance divide.
// Depends on rwcp_pkg.
`default_nettype none
module rwcp_frontend import rwcp_pkg::*; (
	input  wire logic [POS_W-1:0]        viewer_x,
	input  wire logic [POS_W-1:0]        viewer_y,
	input  wire logic signed [DIR_W-1:0] dir_x,
	input  wire logic signed [DIR_W-1:0] dir_y,
	input  wire logic [CELL_W-1:0]       hit_cell_x,
	input  wire logic [CELL_W-1:0]       hit_cell_y,
	input  wire logic                    hit_face,
	output front_t                       front
);

	logic [CELL_W-1:0]       cell_sel;
	logic [POS_W-1:0]        pos;
	logic signed [DIR_W-1:0] dir;
	logic                    neg;
	logic [CELL_W:0]         cadj;
	logic signed [NUM_W:0]   num;
	logic [NUM_W:0]          num_mag;
	logic [DIR_W-1:0]        dir_mag;

	always_comb begin
		cell_sel = hit_face ? hit_cell_y : hit_cell_x;
		pos      = hit_face ? viewer_y : viewer_x;
		dir      = hit_face ? dir_y : dir_x;
		neg      = dir[DIR_W-1];
		// far edge of the cell when stepping negative
		cadj     = {1'b0, cell_sel} + {{CELL_W{1'b0}}, neg};
		num      = $signed({1'b0, cadj, {FRAC{1'b0}}}) - $signed({2'b00, pos});
		num_mag  = num[NUM_W] ? (NUM_W+1)'(-num) : num;
		dir_mag  = neg ? DIR_W'(-dir) : dir;

		front.abs_num  = num_mag[NUM_W-1:0];
		front.abs_dir  = dir_mag;
		front.q_pos    = (num != '0) && (num[NUM_W] == neg);
		front.dir_zero = (dir == '0);
		front.wall_pos = hit_face ? viewer_x : viewer_y;
		front.wall_dir = hit_face ? dir_x : dir_y;
		front.mirror   = hit_face ? dir_y[DIR_W-1] : ((dir_x != '0) && !dir_x[DIR_W-1]);
	end

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for ray_wall_column_projection: random and directed rays, one result each.
// Depends on rwcp_pkg and the block's RTL; holds its own predictor of the projection.
`timescale 1ns / 100ps
`default_nettype none

class column_scoreboard;
	logic [87:0] pending_columns[$];
	int fails;

	function new();
		fails = 0;
	endfunction

	// integer model of one ray, packed as the output word
	function automatic logic [87:0] project_ray(logic [103:0] d, logic face);
		longint vx, vy, dx, dy, cx, cy, cell_sel, pos, dir, num, q, wall;
		longint unsigned perp, lh, half, ds, de, frac, col, step, start, hitv;
		vx = d[21:0];
		vy = d[43:22];
		dx = longint'($signed(d[67:44]));
		dy = longint'($signed(d[91:68]));
		cx = d[97:92];
		cy = d[103:98];
		cell_sel = face ? cy : cx;
		pos = face ? vy : vx;
		dir = face ? dy : dx;
		if (dir == 0) begin
			perp = 64'hFFFF_FFFF;
		end else begin
			num = (cell_sel + (dir < 0 ? 1 : 0)) * 65536 - pos;
			q = (num * 65536) / dir;
			if (q <= 0) perp = 0;
			else if (q > 64'hFFFF_FFFF) perp = 64'hFFFF_FFFF;
			else perp = q;
		end
		if (perp == 0) begin
			lh = 65535;
		end else begin
			lh = (longint'(rwcp_pkg::SCREEN_ROWS) * 65536) / perp;
			if (lh > 65535) lh = 65535;
		end
		half = rwcp_pkg::SCREEN_ROWS / 2;
		ds = (lh / 2 >= half) ? 0 : half - lh / 2;
		de = half + lh / 2;
		if (de > rwcp_pkg::SCREEN_ROWS - 1) de = rwcp_pkg::SCREEN_ROWS - 1;
		wall = face ? vx * 65536 + longint'(perp) * dx : vy * 65536 + longint'(perp) * dy;
		frac = (longint'(wall) >>> 16) & 64'hFFFF;
		col = (frac * rwcp_pkg::TEXTURE_WIDTH) >> 16;
		if ((!face && dx > 0) || (face && dy < 0)) col = rwcp_pkg::TEXTURE_WIDTH - 1 - col;
		if (lh == 0) begin
			step = 64'hFF_FFFF;
		end else begin
			step = (longint'(rwcp_pkg::TEXTURE_HEIGHT) * 65536) / lh;
			if (step > 64'hFF_FFFF) step = 64'hFF_FFFF;
		end
		hitv = ds + lh / 2 - half;
		start = hitv * step;
		if (hitv != 0 && (start / hitv != step || start > 64'h3F_FFFF)) start = 64'h3F_FFFF;
		return {1'b0, start[22:0], step[23:0], col[5:0], de[8:0], ds[8:0], lh[15:0]};
	endfunction

	function void note_ray(logic [103:0] d, logic face);
		pending_columns.push_back(project_ray(d, face));
	endfunction

	function void check_column(logic [87:0] got);
		logic [87:0] want;
		if (pending_columns.size() == 0) begin
			$error("column word with none pending: %h", got);
			fails++;
			return;
		end
		want = pending_columns.pop_front();
		if (got[15:0] !== want[15:0]) begin
			$error("wall_rows exp %0d got %0d", want[15:0], got[15:0]); fails++;
		end
		if (got[24:16] !== want[24:16]) begin
			$error("top_row exp %0d got %0d", want[24:16], got[24:16]); fails++;
		end
		if (got[33:25] !== want[33:25]) begin
			$error("bottom_row exp %0d got %0d", want[33:25], got[33:25]); fails++;
		end
		if (got[39:34] !== want[39:34]) begin
			$error("tex_column exp %0d got %0d", want[39:34], got[39:34]); fails++;
		end
		if (got[63:40] !== want[63:40]) begin
			$error("tex_step exp %0d got %0d", want[63:40], got[63:40]); fails++;
		end
		if (got[86:64] !== want[86:64]) begin
			$error("tex_start exp %0d got %0d", want[86:64], got[86:64]); fails++;
		end
	endfunction
endclass

module testbench;
	import rwcp_pkg::*;

	localparam int LATENCY = 96;
	localparam int RANDOM_RAYS = 1600;
	localparam longint CYCLE_LIMIT = 400000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [87:0]  m_tdata;

	column_scoreboard sb;
	bit   calm_tail = 0;      // no idling in the closing stretch
	bit   hold_sink = 0;      // long receiver hold-off requested
	longint cycles = 0;

	ray_wall_column_projection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: check on each accepted word, stall in bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_column(m_tdata);
	end

	initial begin : sink
		int burst;
		wait (arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end
			if (!calm_tail && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 4);
				m_tready <= 0;
				repeat (burst) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// offer one ray, hold until taken; optional gap before it
	task automatic send_ray(logic [103:0] d, logic face);
		int gap;
		if (!calm_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		s_tuser <= face;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_ray(d, face);
	endtask

	function automatic logic [103:0] pack_ray(logic [21:0] vx, logic [21:0] vy,
			logic [23:0] dx, logic [23:0] dy, logic [5:0] cx, logic [5:0] cy);
		return {cy, cx, dy, dx, vy, vx};
	endfunction

	// mostly plausible rays: wall ahead of the viewer, moderate directions
	function automatic logic [104:0] random_ray();
		logic [21:0] vx, vy;
		logic [23:0] dx, dy;
		logic [5:0] cx, cy;
		logic face;
		vx = 22'($urandom); vy = 22'($urandom);
		dx = 24'($urandom); dy = 24'($urandom);
		cx = 6'($urandom); cy = 6'($urandom);
		face = 1'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			default: begin
				dx = 24'($signed($urandom_range(0, 131072)) - 65536);
				dy = 24'($signed($urandom_range(0, 131072)) - 65536);
				cx = vx[21:16] + 6'(($signed(dx) < 0) ? -$urandom_range(0, 8)
				                                      : $urandom_range(0, 8));
				cy = vy[21:16] + 6'(($signed(dy) < 0) ? -$urandom_range(0, 8)
				                                      : $urandom_range(0, 8));
			end
		endcase
		return {face, pack_ray(vx, vy, dx, dy, cx, cy)};
	endfunction

	task automatic drain();
		while (sb.pending_columns.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [104:0] r;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, zero direction, wall behind, zero distance, both faces
		send_ray(pack_ray(22'h0, 22'h0, 24'h0, 24'h0, 6'd0, 6'd0), 0);
		send_ray(pack_ray(22'h0, 22'h0, 24'h0, 24'h0, 6'd0, 6'd0), 1);
		send_ray(pack_ray('1, '1, 24'h7FFFFF, 24'h800000, '1, '1), 0);
		send_ray(pack_ray('1, '1, 24'h7FFFFF, 24'h800000, '1, '1), 1);
		send_ray(pack_ray('1, '1, 24'h800000, 24'h7FFFFF, 6'd0, 6'd0), 0);
		send_ray(pack_ray('1, '1, 24'h800000, 24'h7FFFFF, 6'd0, 6'd0), 1);
		send_ray(pack_ray(22'h20000, 22'h28000, 24'h10000, 24'h08000, 6'd2, 6'd2), 0);
		send_ray(pack_ray(22'h20000, 22'h28000, 24'h10000, 24'h08000, 6'd2, 6'd2), 1);
		send_ray(pack_ray(22'h18000, 22'h18000, 24'h10000, 24'h00001, 6'd5, 6'd1), 0);
		send_ray(pack_ray(22'h18000, 22'h18000, 24'hFF0000, 24'hFFFFFF, 6'd0, 6'd0), 1);
		send_ray(pack_ray(22'h18000, 22'h18000, 24'hFF0000, 24'hFF0000, 6'd0, 6'd0), 0);
		send_ray(pack_ray(22'h18000, 22'h18000, 24'h000001, 24'h000001, 6'd63, 6'd63), 0);
		send_ray(pack_ray(22'h18000, 22'h18000, 24'h000001, 24'h000001, 6'd63, 6'd63), 1);
		send_ray(pack_ray(22'h3F0000, 22'h010000, 24'h7FFFFF, 24'h10000, 6'd63, 6'd1), 0);
		send_ray(pack_ray(22'h10000, 22'h3FFFFF, 24'h00100, 24'hFFFF00, 6'd1, 6'd0), 1);
		send_ray(pack_ray(22'h15555, 22'h2AAAA, 24'h555555, 24'hAAAAAA, 6'h15, 6'h2A), 0);
		send_ray(pack_ray(22'h2AAAA, 22'h15555, 24'hAAAAAA, 24'h555555, 6'h2A, 6'h15), 1);

		// sender pauses until every column is back
		s_tvalid <= 0;
		drain();

		for (int i = 0; i < RANDOM_RAYS; i++) begin
			if (i == 400) hold_sink = 1;   // sender keeps offering while the sink holds off
			if (i == 800) begin
				s_tvalid <= 0;
				drain();
			end
			if (i == RANDOM_RAYS - 200) calm_tail = 1;
			r = random_ray();
			send_ray(r[103:0], r[104]);
		end
		s_tvalid <= 0;
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.fails == 0 && sb.pending_columns.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire

[filelist.f]
design/rwcp_pkg.sv
design/rwcp_frontend.sv
design/ray_wall_column_projection.sv
bench/testbench.sv
